### sv/hpcc_pkg.sv
// ---------------------------------------------------------------------------
// hpcc_pkg: shared types and constants
// Item structs, table geometry, status codes and table record layouts for
// the host/port connection counter.
// ---------------------------------------------------------------------------
`default_nettype none

package hpcc_pkg;

    // Table geometry
    localparam int HOST_SLOTS     = 64;
    localparam int PORTS_PER_HOST = 16;
    localparam int ENTRY_COUNT    = HOST_SLOTS * PORTS_PER_HOST;
    localparam int HIDX_W         = $clog2(HOST_SLOTS);
    localparam int HCNT_W         = $clog2(HOST_SLOTS + 1);
    localparam int PIDX_W         = $clog2(PORTS_PER_HOST);
    localparam int PCNT_W         = $clog2(PORTS_PER_HOST + 1);
    localparam int ENTRY_W        = $clog2(ENTRY_COUNT);

    // Packet filter constants
    localparam logic [3:0]  IP_V4        = 4'd4;
    localparam logic [15:0] PORT_LIMIT   = 16'd1024;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  OCTET_BCAST  = 8'd255;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    // Operations
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_COUNTED    = 3'd0;
    localparam logic [2:0] ST_NEW        = 3'd1;
    localparam logic [2:0] ST_IGNORED    = 3'd2;
    localparam logic [2:0] ST_HOSTS_FULL = 3'd3;
    localparam logic [2:0] ST_PORTS_FULL = 3'd4;
    localparam logic [2:0] ST_EMPTY      = 3'd5;
    localparam logic [2:0] ST_READ_OK    = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_EXTRA_PORTS = 2'd1;
    localparam logic [1:0] CFG_REQ_VERIFY  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [3:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [5:0]  read_host;
        logic [3:0]  read_port;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  host_slot;
        logic [3:0]  port_slot;
        logic [31:0] host_address;
        logic [15:0] port_number;
        logic [31:0] tcp_count;
        logic [31:0] udp_count;
        logic        host_verified;
        logic        tcp_over;
        logic        udp_over;
        logic        reportable;
    } out_item_t;

    // Host table record: address, seen-twice mark, ports in use
    typedef struct packed {
        logic [31:0]       addr;
        logic              seen;
        logic [PCNT_W-1:0] pcnt;
    } host_rec_t;

    // Port table record
    typedef struct packed {
        logic [15:0] port;
        logic [31:0] tcp;
        logic [31:0] udp;
    } port_rec_t;

    localparam int HREC_W = $bits(host_rec_t);
    localparam int PREC_W = $bits(port_rec_t);

    // Flat port table address of (host, port slot)
    function automatic logic [ENTRY_W-1:0] entry_addr(input logic [HIDX_W-1:0] h,
                                                      input logic [PIDX_W-1:0] p);
        entry_addr = ENTRY_W'(ENTRY_W'(h) * ENTRY_W'(PORTS_PER_HOST) + ENTRY_W'(p));
    endfunction

    // Saturating increment
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    // Broadcast octet, or dotted text holding "0.0.0.0"
    function automatic logic addr_rejected(input logic [31:0] a);
        logic mult10;
        mult10 = 1'b0;
        for (int k = 0; k < 26; k++) begin
            if (a[31:24] == 8'(k * 10)) begin
                mult10 = 1'b1;
            end
        end
        addr_rejected = (a[31:24] == OCTET_BCAST) || (a[23:16] == OCTET_BCAST) ||
                        (a[15:8] == OCTET_BCAST) || (a[7:0] == OCTET_BCAST) ||
                        ((a[23:0] == 24'd0) && mult10);
    endfunction

endpackage

`default_nettype wire

### sv/host_port_connection_counter.sv
// ---------------------------------------------------------------------------
// host_port_connection_counter: per-host, per-port TCP/UDP packet counter
// Observe items carry parsed IPv4 header fields; read items fetch one slot.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one in_item_t per item (valid/ready); m_* returns exactly one
//   out_item_t per item (valid/ready). cfg_* writes count_threshold (0),
//   extra_ports (1) and require_verified (2); it is always ready.
//   Items are handled one at a time. Host records sit in a 64-entry RAM and
//   port records in a 1024-entry RAM, both with registered reads.
//   Steps: a filtered packet or a read of an untaken host slot goes straight
//   to the output; a read fetches the host record, then the port record.
//   An observe item scans the host records one by one up to the fill count;
//   with no match it adds the host, or reports hosts full. For a known host it
//   scans the port slots until the matching port or the first free slot.
//   A finished result sits in the output register; the next item is taken
//   while it waits. When m_ready stays low, the following result waits in
//   its own holding stage and no further item is accepted.
//   Reset clears the host fill count and the output valid and sets the state and
//   configuration registers to their defaults; slots are only read below the fill
//   counts, so the RAMs need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module host_port_connection_counter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire hpcc_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hpcc_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import hpcc_pkg::*;

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDH  = 4'd1;
    localparam logic [3:0] S_RDHD = 4'd2;
    localparam logic [3:0] S_RDPD = 4'd3;
    localparam logic [3:0] S_HRD  = 4'd4;
    localparam logic [3:0] S_HCMP = 4'd5;
    localparam logic [3:0] S_PRD  = 4'd6;
    localparam logic [3:0] S_PCMP = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [HCNT_W-1:0] idx_reg, idx_next;
    logic [HIDX_W-1:0] hidx_reg, hidx_next;
    host_rec_t         hrec_reg, hrec_next;
    logic [PCNT_W-1:0] pidx_reg, pidx_next;
    out_item_t         res_reg, res_next;
    out_item_t         m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;
    logic [HCNT_W-1:0] hosts_reg, hosts_next;
    logic [31:0]       thr_reg;
    logic              extra_reg;
    logic              reqv_reg;

    // RAM ports
    logic              h_we;
    logic [HIDX_W-1:0] h_waddr, h_raddr;
    host_rec_t         h_wdata, h_rdata;
    logic              p_we;
    logic [ENTRY_W-1:0] p_waddr, p_raddr;
    port_rec_t         p_wdata, p_rdata;

    logic [HREC_W-1:0] h_rdata_raw;
    logic [PREC_W-1:0] p_rdata_raw;

    hpcc_ram #(.WIDTH(HREC_W), .DEPTH(HOST_SLOTS)) u_host_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata_raw)
    );

    hpcc_ram #(.WIDTH(PREC_W), .DEPTH(ENTRY_COUNT)) u_port_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata_raw)
    );

    assign h_rdata = host_rec_t'(h_rdata_raw);
    assign p_rdata = port_rec_t'(p_rdata_raw);

    // Build a result item with threshold flags
    function automatic out_item_t make_res(input logic [2:0] st,
                                           input logic [HIDX_W-1:0] h,
                                           input logic [PIDX_W-1:0] p,
                                           input logic [31:0] addr,
                                           input logic [15:0] port,
                                           input logic [31:0] tcp,
                                           input logic [31:0] udp,
                                           input logic ver,
                                           input logic [31:0] thr,
                                           input logic reqv);
        out_item_t r;
        r.status        = st;
        r.host_slot     = 6'(h);
        r.port_slot     = 4'(p);
        r.host_address  = addr;
        r.port_number   = port;
        r.tcp_count     = tcp;
        r.udp_count     = udp;
        r.host_verified = ver;
        r.tcp_over      = (tcp >= thr);
        r.udp_over      = (udp >= thr);
        r.reportable    = (!reqv || ver) && (r.tcp_over || r.udp_over);
        make_res = r;
    endfunction

    logic       out_free;
    logic       filtered;
    logic [31:0] tcp_new, udp_new;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Packet filter on the incoming item
    assign filtered = (s_data.ip_version != IP_V4) || (s_data.dest_port == 16'd0) ||
                      ((s_data.dest_port > PORT_LIMIT) && !extra_reg) ||
                      addr_rejected(s_data.dest_address);

    // Protocol count update of the port record just read
    always_comb begin
        tcp_new = p_rdata.tcp;
        udp_new = p_rdata.udp;
        if (item_reg.ip_protocol == PROTO_TCP) begin
            tcp_new = sat_inc(p_rdata.tcp);
        end else if (item_reg.ip_protocol == PROTO_UDP) begin
            udp_new = sat_inc(p_rdata.udp);
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        hidx_next    = hidx_reg;
        hrec_next    = hrec_reg;
        pidx_next    = pidx_reg;
        res_next     = res_reg;
        hosts_next   = hosts_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        h_we         = 1'b0;
        h_waddr      = hidx_reg;
        h_wdata      = hrec_reg;
        h_raddr      = HIDX_W'(idx_reg);
        p_we         = 1'b0;
        p_waddr      = entry_addr(hidx_reg, PIDX_W'(pidx_reg));
        p_wdata      = '0;
        p_raddr      = entry_addr(hidx_reg, PIDX_W'(pidx_reg));

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    if (s_data.op == OP_READ) begin
                        if (32'(s_data.read_host) >= 32'(HOST_SLOTS) ||
                            32'(s_data.read_host) >= 32'(hosts_reg)) begin
                            res_next           = '0;
                            res_next.status    = ST_EMPTY;
                            res_next.host_slot = s_data.read_host;
                            res_next.port_slot = s_data.read_port;
                            state_next         = S_OUT;
                        end else begin
                            state_next = S_RDH;
                        end
                    end else if (filtered) begin
                        res_next        = '0;
                        res_next.status = ST_IGNORED;
                        state_next      = S_OUT;
                    end else begin
                        idx_next   = '0;
                        state_next = S_HRD;
                    end
                end
            end
            S_RDH: begin
                h_raddr    = HIDX_W'(item_reg.read_host);
                state_next = S_RDHD;
            end
            S_RDHD: begin
                hrec_next = h_rdata;
                p_raddr   = entry_addr(HIDX_W'(item_reg.read_host),
                                       PIDX_W'(item_reg.read_port));
                if (32'(item_reg.read_port) >= 32'(PORTS_PER_HOST) ||
                    32'(item_reg.read_port) >= 32'(h_rdata.pcnt)) begin
                    res_next           = '0;
                    res_next.status    = ST_EMPTY;
                    res_next.host_slot = item_reg.read_host;
                    res_next.port_slot = item_reg.read_port;
                    state_next         = S_OUT;
                end else begin
                    state_next = S_RDPD;
                end
            end
            S_RDPD: begin
                res_next   = make_res(ST_READ_OK, HIDX_W'(item_reg.read_host),
                                      PIDX_W'(item_reg.read_port), hrec_reg.addr,
                                      p_rdata.port, p_rdata.tcp, p_rdata.udp,
                                      hrec_reg.seen, thr_reg, reqv_reg);
                state_next = S_OUT;
            end
            S_HRD: begin
                if (idx_reg == hosts_reg) begin
                    if (32'(hosts_reg) >= 32'(HOST_SLOTS)) begin
                        res_next        = '0;
                        res_next.status = ST_HOSTS_FULL;
                    end else begin
                        // New host: first port in slot 0, zero counts
                        h_we          = 1'b1;
                        h_waddr       = HIDX_W'(hosts_reg);
                        h_wdata.addr  = item_reg.dest_address;
                        h_wdata.seen  = 1'b0;
                        h_wdata.pcnt  = PCNT_W'(1);
                        p_we          = 1'b1;
                        p_waddr       = entry_addr(HIDX_W'(hosts_reg), '0);
                        p_wdata.port  = item_reg.dest_port;
                        p_wdata.tcp   = '0;
                        p_wdata.udp   = '0;
                        hosts_next    = hosts_reg + HCNT_W'(1);
                        res_next      = make_res(ST_NEW, HIDX_W'(hosts_reg), '0,
                                                 item_reg.dest_address,
                                                 item_reg.dest_port, '0, '0, 1'b0,
                                                 thr_reg, reqv_reg);
                    end
                    state_next = S_OUT;
                end else begin
                    state_next = S_HCMP;
                end
            end
            S_HCMP: begin
                if (h_rdata.addr == item_reg.dest_address) begin
                    hidx_next  = HIDX_W'(idx_reg);
                    hrec_next  = h_rdata;
                    pidx_next  = '0;
                    state_next = S_PRD;
                end else begin
                    idx_next   = idx_reg + HCNT_W'(1);
                    state_next = S_HRD;
                end
            end
            S_PRD: begin
                if (pidx_reg == hrec_reg.pcnt) begin
                    if (32'(hrec_reg.pcnt) >= 32'(PORTS_PER_HOST)) begin
                        // Ports full: still mark the host seen twice
                        h_we          = 1'b1;
                        h_wdata.seen  = 1'b1;
                        res_next               = '0;
                        res_next.status        = ST_PORTS_FULL;
                        res_next.host_slot     = 6'(hidx_reg);
                        res_next.host_address  = hrec_reg.addr;
                        res_next.host_verified = 1'b1;
                    end else begin
                        // Add the port, then count it
                        h_we         = 1'b1;
                        h_wdata.seen = 1'b1;
                        h_wdata.pcnt = hrec_reg.pcnt + PCNT_W'(1);
                        p_we         = 1'b1;
                        p_wdata.port = item_reg.dest_port;
                        p_wdata.tcp  = {31'd0, item_reg.ip_protocol == PROTO_TCP};
                        p_wdata.udp  = {31'd0, item_reg.ip_protocol == PROTO_UDP};
                        res_next     = make_res(ST_COUNTED, hidx_reg, PIDX_W'(pidx_reg),
                                                hrec_reg.addr, p_wdata.port,
                                                p_wdata.tcp, p_wdata.udp, 1'b1,
                                                thr_reg, reqv_reg);
                    end
                    state_next = S_OUT;
                end else begin
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                if (p_rdata.port == item_reg.dest_port) begin
                    h_we         = 1'b1;
                    h_wdata.seen = 1'b1;
                    p_we         = 1'b1;
                    p_wdata.port = p_rdata.port;
                    p_wdata.tcp  = tcp_new;
                    p_wdata.udp  = udp_new;
                    res_next     = make_res(ST_COUNTED, hidx_reg, PIDX_W'(pidx_reg),
                                            hrec_reg.addr, p_rdata.port, tcp_new,
                                            udp_new, 1'b1, thr_reg, reqv_reg);
                    state_next   = S_OUT;
                end else begin
                    pidx_next  = pidx_reg + PCNT_W'(1);
                    state_next = S_PRD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            hosts_reg   <= '0;
            thr_reg     <= 32'd1;
            extra_reg   <= 1'b0;
            reqv_reg    <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            hosts_reg   <= hosts_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_THRESHOLD:   thr_reg   <= cfg_data;
                    CFG_EXTRA_PORTS: extra_reg <= cfg_data[0];
                    CFG_REQ_VERIFY:  reqv_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        hidx_reg   <= hidx_next;
        hrec_reg   <= hrec_next;
        pidx_reg   <= pidx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

### sv/hpcc_ram.sv
// ---------------------------------------------------------------------------
// hpcc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module hpcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/hpcc_checker.sv
// ---------------------------------------------------------------------------
// hpcc_checker: port-level checks for host_port_connection_counter
// Watches the result channel and checks result consistency over time.
// ---------------------------------------------------------------------------
`default_nettype none

module hpcc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire hpcc_pkg::out_item_t m_data
);
    import hpcc_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reportable only with a count at or over threshold
    a_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_data.reportable || m_data.tcp_over || m_data.udp_over)
        else $error("reportable without an over flag");

    // Ignored and hosts-full results carry no table contents
    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_IGNORED || m_data.status == ST_HOSTS_FULL) |->
        m_data.host_address == 32'd0 && m_data.tcp_count == 32'd0 &&
        m_data.udp_count == 32'd0 && !m_data.host_verified)
        else $error("dropped item carries table data");

    // Accepting an item drops s_ready: no second item is taken while one is in progress
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

endmodule

bind host_port_connection_counter hpcc_checker u_hpcc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
